// ===== rtl/core/prq_pkg.sv =====
// ----------------------------------------------------------------------------
// prq_pkg
// Shared types and constants of the priority request queue: request and
// response payloads, the stored entry and the control word of the cell chain.
// ----------------------------------------------------------------------------
package prq_pkg;

   localparam int CAPACITY_DEF = 64;

   typedef enum logic [1:0] {
      MODE_ADD    = 2'd0,
      MODE_EDIT   = 2'd1,
      MODE_REMOVE = 2'd2,
      MODE_POP    = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_EMPTY     = 2'd1,
      ST_FULL      = 2'd2,
      ST_NOT_FOUND = 2'd3
   } status_type;

   typedef struct packed {
      mode_type    mode;
      logic [15:0] meeting_id;
      logic [15:0] start_time;
      logic [15:0] end_time;
      logic [31:0] priority_req;
   } req_type;

   typedef struct packed {
      logic [15:0] served_id;
      status_type  status;
   } rsp_type;

   typedef struct packed {
      logic        valid;
      logic [15:0] id;
      logic [15:0] start_t;
      logic [15:0] end_t;
      logic [31:0] prio;
   } entry_type;

   typedef enum logic [2:0] {
      CELL_HOLD    = 3'd0,
      CELL_MATCH   = 3'd1,
      CELL_SCAN    = 3'd2,
      CELL_COMPACT = 3'd3,
      CELL_POP     = 3'd4,
      CELL_INSERT  = 3'd5
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
      entry_type   cmd;
   } cell_ctl_type;

endpackage

// ===== rtl/core/priority_request_queue_unit.sv =====
// ----------------------------------------------------------------------------
// priority_request_queue_unit
// Keyed priority queue built as a sorted chain of entry cells.
// ----------------------------------------------------------------------------
// The queue keeps up to CAPACITY entries (id, start, end, priority) in a chain
// of cells sorted by rank: highest priority first, then earliest start, then
// smallest id, with all empty cells at the tail. A pop takes the head cell and
// shifts the chain left at the accept edge; the reply state loads the
// response. Add, edit and remove first look up the id: every cell compares
// it, then a log-step prefix OR across the chain, one doubling of the reach
// per cycle, marks the hit and everything behind it. An add or edit then
// goes on through the remove and insert states; a remove or a rejected
// add/edit goes from the remove state to the reply. A hit is removed by
// shifting the cells behind it left; the new entry is then placed in the
// insert state, each cell choosing between keeping its entry, taking its
// left neighbor's, or taking the new one. One request is in flight at a
// time; a finished response sits in an output register while the next
// request is taken. All cells' valid marks clear at reset, no clearing pass.
// ----------------------------------------------------------------------------
module priority_request_queue_unit #(
   parameter int CAPACITY = prq_pkg::CAPACITY_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  prq_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output prq_pkg::rsp_type rsp_data
);
   import prq_pkg::*;

   // number of prefix doubling steps to cover the whole chain
   localparam int STEPS = $clog2(CAPACITY);

   cell_ctl_type  ctl;
   logic [STEPS-1:0] scan_mask;

   // per-cell outputs
   entry_type     cell_entry [CAPACITY];
   logic [CAPACITY-1:0] cell_pfx;
   logic [CAPACITY-1:0] cell_ahead;

   // neighbor wiring into each cell
   entry_type        left_entry  [CAPACITY];
   entry_type        right_entry [CAPACITY];
   logic [CAPACITY-1:0] left_ahead;
   logic [STEPS-1:0] far_pfx [CAPACITY];

   // sequencer and response register
   prq_ctrl #(
      .STEPS (STEPS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data),
      .head_entry (cell_entry[0]),
      .tail_valid (cell_entry[CAPACITY-1].valid),
      .found      (cell_pfx[CAPACITY-1]),   // tail prefix bit: id present anywhere
      .ctl        (ctl),
      .scan_mask  (scan_mask)
   );

   // the chain itself, cell 0 holds the top entry
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      if (i == 0) begin : g_head
         assign left_entry[i] = '0;
         assign left_ahead[i] = 1'b0;
      end else begin : g_body
         assign left_entry[i] = cell_entry[i-1];
         assign left_ahead[i] = cell_ahead[i-1];
      end

      if (i == CAPACITY-1) begin : g_tail
         assign right_entry[i] = '0;   // an empty slot enters at the tail
      end else begin : g_inner
         assign right_entry[i] = cell_entry[i+1];
      end

      // prefix bits from 1, 2, 4, ... cells up the chain
      for (genvar s = 0; s < STEPS; s++) begin : g_far
         if (i >= (1 << s)) begin : g_tap
            assign far_pfx[i][s] = cell_pfx[i-(1<<s)];
         end else begin : g_none
            assign far_pfx[i][s] = 1'b0;
         end
      end

      prq_cell #(
         .STEPS (STEPS)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctl         (ctl),
         .scan_mask   (scan_mask),
         .far_pfx     (far_pfx[i]),
         .left_entry  (left_entry[i]),
         .left_ahead  (left_ahead[i]),
         .right_entry (right_entry[i]),
         .entry       (cell_entry[i]),
         .pfx         (cell_pfx[i]),
         .ahead       (cell_ahead[i])
      );
   end

endmodule

// ===== rtl/core/prq_cell.sv =====
// ----------------------------------------------------------------------------
// prq_cell
// One slot of the sorted chain: holds an entry and a prefix-match bit, and
// trades entries with its left and right neighbors.
// ----------------------------------------------------------------------------
module prq_cell #(
   parameter int STEPS = 6
) (
   input  logic                  clock,
   input  logic                  reset,
   input  prq_pkg::cell_ctl_type ctl,
   input  logic [STEPS-1:0]      scan_mask,
   input  logic [STEPS-1:0]      far_pfx,
   input  prq_pkg::entry_type    left_entry,
   input  logic                  left_ahead,
   input  prq_pkg::entry_type    right_entry,
   output prq_pkg::entry_type    entry,
   output logic                  pfx,
   output logic                  ahead
);
   import prq_pkg::*;

   entry_type entry_ff, entry_in;
   logic      pfx_ff, pfx_in;

   // new entry ranks ahead of this slot (an empty slot loses to anything)
   always_comb begin
      if (!entry_ff.valid) begin
         ahead = 1'b1;
      end else if (ctl.cmd.prio != entry_ff.prio) begin
         ahead = ctl.cmd.prio > entry_ff.prio;
      end else if (ctl.cmd.start_t != entry_ff.start_t) begin
         ahead = ctl.cmd.start_t < entry_ff.start_t;
      end else begin
         ahead = ctl.cmd.id < entry_ff.id;
      end
   end

   always_comb begin
      entry_in = entry_ff;
      pfx_in   = pfx_ff;
      unique case (ctl.op)
         CELL_HOLD: begin
         end
         CELL_MATCH: begin
            pfx_in = entry_ff.valid && (entry_ff.id == ctl.cmd.id);
         end
         CELL_SCAN: begin
            pfx_in = pfx_ff | (|(far_pfx & scan_mask));
         end
         CELL_COMPACT: begin
            if (pfx_ff) begin
               entry_in = right_entry;
            end
         end
         CELL_POP: begin
            entry_in = right_entry;
         end
         CELL_INSERT: begin
            if (left_ahead) begin
               entry_in = left_entry;
            end else if (ahead) begin
               entry_in = ctl.cmd;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= '0;
         pfx_ff   <= 1'b0;
      end else begin
         entry_ff <= entry_in;
         pfx_ff   <= pfx_in;
      end
   end

   assign entry = entry_ff;
   assign pfx   = pfx_ff;

endmodule

// ===== rtl/core/prq_ctrl.sv =====
// ----------------------------------------------------------------------------
// prq_ctrl
// Command sequencer: takes requests, steps the cell chain through pop, lookup,
// prefix scan, compaction and insertion, and holds the response register.
// ----------------------------------------------------------------------------
module prq_ctrl #(
   parameter int STEPS = 6
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  prq_pkg::req_type      req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output prq_pkg::rsp_type      rsp_data,
   input  prq_pkg::entry_type    head_entry,
   input  logic                  tail_valid,
   input  logic                  found,
   output prq_pkg::cell_ctl_type ctl,
   output logic [STEPS-1:0]      scan_mask
);
   import prq_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_MATCH,
      S_SCAN,
      S_REMOVE,
      S_INSERT,
      S_REPLY
   } state_type;

   state_type        state_ff, state_in;
   req_type          cmd_ff, cmd_in;
   logic [STEPS-1:0] mask_ff, mask_in;
   rsp_type          res_ff, res_in;
   rsp_type          rsp_ff, rsp_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             accept;
   cell_op_type      cell_op;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;

   assign ctl.op          = cell_op;
   assign ctl.cmd.valid   = 1'b1;
   assign ctl.cmd.id      = cmd_ff.meeting_id;
   assign ctl.cmd.start_t = cmd_ff.start_time;
   assign ctl.cmd.end_t   = cmd_ff.end_time;
   assign ctl.cmd.prio    = cmd_ff.priority_req;

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      mask_in      = mask_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cell_op      = CELL_HOLD;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd_in = req_data;
               if (req_data.mode == MODE_POP) begin
                  // top entry leaves at the accept edge
                  if (head_entry.valid) begin
                     cell_op          = CELL_POP;
                     res_in.served_id = head_entry.id;
                     res_in.status    = ST_OK;
                  end else begin
                     res_in.served_id = '0;
                     res_in.status    = ST_EMPTY;
                  end
                  state_in = S_REPLY;
               end else begin
                  state_in = S_MATCH;
               end
            end
         end
         S_MATCH: begin
            cell_op  = CELL_MATCH;
            mask_in  = STEPS'(1);
            state_in = S_SCAN;
         end
         S_SCAN: begin
            cell_op = CELL_SCAN;
            mask_in = mask_ff << 1;
            if (mask_ff[STEPS-1]) begin
               state_in = S_REMOVE;
            end
         end
         S_REMOVE: begin
            if (found) begin
               cell_op = CELL_COMPACT;
            end
            res_in.served_id = '0;
            res_in.status    = ST_OK;
            unique case (cmd_ff.mode)
               MODE_ADD: begin
                  if (!found && tail_valid) begin
                     res_in.status = ST_FULL;
                     state_in      = S_REPLY;
                  end else begin
                     state_in = S_INSERT;
                  end
               end
               MODE_EDIT: begin
                  if (found) begin
                     state_in = S_INSERT;
                  end else begin
                     res_in.status = ST_NOT_FOUND;
                     state_in      = S_REPLY;
                  end
               end
               MODE_REMOVE: begin
                  if (!found) begin
                     res_in.status = ST_NOT_FOUND;
                  end
                  state_in = S_REPLY;
               end
               default: begin
                  state_in = S_REPLY;
               end
            endcase
         end
         S_INSERT: begin
            cell_op          = CELL_INSERT;
            res_in.served_id = '0;
            res_in.status    = ST_OK;
            state_in         = S_REPLY;
         end
         S_REPLY: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         mask_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         mask_ff      <= mask_in;
      end
      cmd_ff <= cmd_in;
      res_ff <= res_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign scan_mask = mask_ff;

endmodule

// ===== verif/prq_queue_checker.sv =====
// ----------------------------------------------------------------------------
// prq_queue_checker
// Watches both channels of the priority request queue, keeps its own copy of
// the queue contents, and compares every response transfer field by field
// with the response owed for the oldest outstanding request.
// ----------------------------------------------------------------------------
module prq_queue_checker #(
   parameter int CAPACITY = prq_pkg::CAPACITY_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  prq_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  prq_pkg::rsp_type rsp_data,
   output int               fail_count,
   output int               pending_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import prq_pkg::*;

   // shadow copy of the queue, slot order is irrelevant to the responses
   logic        slot_live   [CAPACITY];
   logic [15:0] slot_key    [CAPACITY];
   logic [15:0] slot_begin  [CAPACITY];
   logic [15:0] slot_finish [CAPACITY];
   logic [31:0] slot_rank   [CAPACITY];

   rsp_type owed_rsp[$];
   int      mismatches = 0;

   assign fail_count = mismatches;

   // applies one command to the shadow queue and returns the response it owes
   function automatic rsp_type apply_command(req_type cmd);
      int      i;
      int      hit;
      int      best;
      rsp_type outcome;
      outcome.served_id = '0;
      outcome.status    = ST_OK;
      hit = -1;
      for (i = 0; i < CAPACITY; i++)
         if (hit < 0 && slot_live[i] && slot_key[i] == cmd.meeting_id) hit = i;
      case (cmd.mode)
         MODE_ADD, MODE_EDIT: begin
            if (hit < 0 && cmd.mode == MODE_ADD)
               for (i = 0; i < CAPACITY; i++)
                  if (hit < 0 && !slot_live[i]) hit = i;
            if (hit < 0) begin
               if (cmd.mode == MODE_ADD) outcome.status = ST_FULL;
               else outcome.status = ST_NOT_FOUND;
            end else begin
               slot_live[hit]   = 1'b1;
               slot_key[hit]    = cmd.meeting_id;
               slot_begin[hit]  = cmd.start_time;
               slot_finish[hit] = cmd.end_time;
               slot_rank[hit]   = cmd.priority_req;
            end
         end
         MODE_REMOVE: begin
            if (hit < 0) outcome.status = ST_NOT_FOUND;
            else slot_live[hit] = 1'b0;
         end
         default: begin
            // highest priority, then earliest start, then smallest id
            best = -1;
            for (i = 0; i < CAPACITY; i++) begin
               if (slot_live[i]) begin
                  if (best < 0) best = i;
                  else if (slot_rank[i] != slot_rank[best]) begin
                     if (slot_rank[i] > slot_rank[best]) best = i;
                  end else if (slot_begin[i] != slot_begin[best]) begin
                     if (slot_begin[i] < slot_begin[best]) best = i;
                  end else if (slot_key[i] < slot_key[best]) best = i;
               end
            end
            if (best < 0) outcome.status = ST_EMPTY;
            else begin
               outcome.served_id = slot_key[best];
               slot_live[best]   = 1'b0;
            end
         end
      endcase
      return outcome;
   endfunction

   always @(posedge clock) begin : watch
      int      i;
      rsp_type want;
      if (reset) begin
         for (i = 0; i < CAPACITY; i++) slot_live[i] = 1'b0;
         owed_rsp.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (owed_rsp.size() == 0) begin
               mismatches++;
               $display("%0t: response with none owed, served_id %h status %0d",
                        $time, rsp_data.served_id, rsp_data.status);
            end else begin
               want = owed_rsp.pop_front();
               if (rsp_data.served_id !== want.served_id) begin
                  mismatches++;
                  $display("%0t: served_id expected %h actual %h",
                           $time, want.served_id, rsp_data.served_id);
               end
               if (rsp_data.status !== want.status) begin
                  mismatches++;
                  $display("%0t: status expected %0d actual %0d",
                           $time, want.status, rsp_data.status);
               end
            end
         end
         if (req_valid && req_ready) owed_rsp.push_back(apply_command(req_data));
      end
      pending_count <= owed_rsp.size();
   end

endmodule

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Top of the priority request queue testbench: drives a directed run over the
// special cases of add, edit, remove and pop, then 1450
// random commands in fill, drain and mixed phases under random bursts and
// stalls; the checker beside the block predicts and compares every response.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import prq_pkg::*;

   localparam int CAPACITY      = CAPACITY_DEF;
   localparam int RANDOM_ITEMS  = 1450;
   localparam int ID_POOL       = 80;    // a bit above capacity so adds can hit full
   localparam int HOLD_CYCLES   = 300;   // long receiver hold-off, block backs up
   localparam int SETTLE_CYCLES = 40;    // wait after the final drain, before the verdict

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;
   int      fail_count;
   int      pending_count;
   bit      hold_off_req = 1'b0;

   priority_request_queue_unit #(.CAPACITY(CAPACITY)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   prq_queue_checker #(.CAPACITY(CAPACITY)) u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   // 2 ns clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // hard stop in case the block hangs
   initial begin
      #2_000_000;
      $display("tb: errors");
      $finish;
   end

   // offer one command and return at the edge of its transfer; ready is looked
   // at on the falling edge, where the block's registered outputs are settled
   task automatic issue(mode_type m, logic [15:0] id, logic [15:0] st,
                        logic [15:0] en, logic [31:0] pr);
      req_type cmd;
      cmd.mode         = m;
      cmd.meeting_id   = id;
      cmd.start_time   = st;
      cmd.end_time     = en;
      cmd.priority_req = pr;
      req_data  <= cmd;
      req_valid <= 1'b1;
      do @(negedge clock); while (!req_ready);
      @(posedge clock);
   endtask

   // drop valid and wait until every owed response has been taken
   task automatic drain_wait();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending_count != 0);
      @(posedge clock);
   endtask

   // receiver: spans of always-ready, light and heavy stalling, plus one long
   // hold-off on request from the sender side
   initial begin : rsp_side
      int stall_pct;
      rsp_ready <= 1'b0;
      forever begin
         if (hold_off_req) begin
            @(posedge clock);
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_off_req = 1'b0;
         end else begin
            case ($urandom_range(0, 2))
               0:       stall_pct = 0;
               1:       stall_pct = 30;
               default: stall_pct = 75;
            endcase
            repeat ($urandom_range(4, 60)) begin
               @(posedge clock);
               rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
            end
         end
      end
   end

   // sender: reset, directed cases, random phases, verdict
   initial begin : req_side
      int          n;
      int          k;
      int          roll;
      int          burst_left;
      int          segment_left;
      int          add_pct;
      int          edit_pct;
      int          remove_pct;
      mode_type    m;
      logic [15:0] id;
      logic [15:0] st;
      logic [31:0] pr;

      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // nothing stored yet: pop reports empty, edit and remove miss
      issue(MODE_POP,    16'h1234, 16'h0000, 16'h0000, 32'h0000_0000);
      issue(MODE_EDIT,   16'h0000, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
      issue(MODE_REMOVE, 16'hFFFF, 16'h0000, 16'h0000, 32'h0000_0000);
      // field extremes
      issue(MODE_ADD,    16'h0000, 16'h0000, 16'hFFFF, 32'h0000_0000);
      issue(MODE_ADD,    16'hFFFF, 16'hFFFF, 16'h0000, 32'hFFFF_FFFF);
      // equal priority: start decides, then id
      issue(MODE_ADD,    16'd5,    16'd10,   16'd100,  32'd7);
      issue(MODE_ADD,    16'd3,    16'd10,   16'd200,  32'd7);
      issue(MODE_ADD,    16'd9,    16'd2,    16'd300,  32'd7);
      // add of an id already present replaces its entry
      issue(MODE_ADD,    16'd5,    16'd1,    16'd400,  32'd7);
      // edit to tie id 9 on priority and start, smaller id wins
      issue(MODE_EDIT,   16'h0000, 16'd2,    16'd500,  32'd7);
      issue(MODE_REMOVE, 16'd3,    16'd0,    16'd0,    32'd0);
      issue(MODE_ADD,    16'd3,    16'd10,   16'hAAAA, 32'd7);
      // five pops empty the queue, the sixth reports empty
      repeat (6) issue(MODE_POP, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
      // popped ids are gone
      issue(MODE_EDIT,   16'd9,    16'd0,    16'd0,    32'd1);
      issue(MODE_REMOVE, 16'h0000, 16'd0,    16'd0,    32'd0);
      drain_wait();

      burst_left   = $urandom_range(1, 30);
      segment_left = 0;
      add_pct      = 0;
      edit_pct     = 0;
      remove_pct   = 0;
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         // phases: fill toward capacity, drain toward empty, or a mix
         if (segment_left == 0) begin
            case ($urandom_range(0, 2))
               0: begin
                  segment_left = $urandom_range(60, 160);
                  add_pct = 80; edit_pct = 5; remove_pct = 5;
               end
               1: begin
                  segment_left = $urandom_range(20, 90);
                  add_pct = 15; edit_pct = 10; remove_pct = 15;
               end
               default: begin
                  segment_left = $urandom_range(20, 90);
                  add_pct = 30; edit_pct = 20; remove_pct = 20;
               end
            endcase
         end
         segment_left--;

         // receiver goes quiet while commands keep coming
         if (n == 500) hold_off_req = 1'b1;
         // one full stop until the queue has answered everything
         if (n == 1000) drain_wait();

         roll = $urandom_range(0, 99);
         if (roll < add_pct) m = MODE_ADD;
         else if (roll < add_pct + edit_pct) m = MODE_EDIT;
         else if (roll < add_pct + edit_pct + remove_pct) m = MODE_REMOVE;
         else m = MODE_POP;

         // ids mostly from a small pool so edits and removes find their target
         k = $urandom_range(0, ID_POOL - 1);
         if ($urandom_range(0, 9) == 0) id = 16'($urandom);
         else if (k == ID_POOL - 1) id = 16'hFFFF;
         else id = 16'(k * 809);

         // narrow ranges of priority and start make ties common
         case ($urandom_range(0, 3))
            0:       st = 16'h0000;
            1:       st = 16'hFFFF;
            2:       st = 16'($urandom_range(0, 3));
            default: st = 16'($urandom);
         endcase
         case ($urandom_range(0, 3))
            0:       pr = 32'h0000_0000;
            1:       pr = 32'hFFFF_FFFF;
            2:       pr = 32'($urandom_range(0, 3));
            default: pr = $urandom;
         endcase

         issue(m, id, st, 16'($urandom), pr);

         // bursts of random length, mostly followed by a short gap
         burst_left--;
         if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 30);
            if ($urandom_range(0, 3) != 0) begin
               req_valid <= 1'b0;
               repeat ($urandom_range(1, 8)) @(posedge clock);
            end
         end
      end

      drain_wait();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0) $display("tb: clean");
      else $display("tb: errors");
      $finish;
   end

endmodule
